### rtl/nearest_palette_color_assert.svh
// Assertion macros shared by the palette search RTL.
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checked after reset is released.
`define NPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included.
`define NPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NPC_ASSERT(lbl, clk, rstn, prop, msg)
`define NPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/npc_pkg.sv
// Shared types and codes for the nearest palette color search.
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

    localparam int CH_W   = 8;
    localparam int SQ_W   = 2 * CH_W;
    localparam int DIST_W = SQ_W + 2;   // sum of three squares of 8-bit values
    localparam int CFG_W  = 5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] tag;
    } npc_entry_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } npc_color_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] score;
        npc_entry_t        entry;
    } npc_cand_t;

endpackage

`default_nettype wire

### rtl/npc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module npc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/npc_dist.sv
// Two-stage squared Euclidean distance unit, shared by every slot of a scan.
`timescale 1ns / 1ps
`default_nettype none

module npc_dist #(
    parameter int SLOT_W = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire npc_pkg::npc_entry_t in_entry,
    input  wire logic [SLOT_W-1:0]   in_slot,
    input  wire npc_pkg::npc_color_t query,
    output npc_pkg::npc_cand_t       cand,
    output logic      [SLOT_W-1:0]   cand_slot,
    output logic                     busy
);

    import npc_pkg::*;

    logic              st1_valid_reg;
    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    npc_entry_t        st1_entry_reg;
    logic [SLOT_W-1:0] st1_slot_reg;

    logic              st2_valid_reg;
    logic [DIST_W-1:0] st2_dist_reg;
    npc_entry_t        st2_entry_reg;
    logic [SLOT_W-1:0] st2_slot_reg;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= in_valid;
            st2_valid_reg <= st1_valid_reg;
        end
        // stage 1: per-channel squares
        sq_r_reg      <= sq_diff(in_entry.red,   query.red);
        sq_g_reg      <= sq_diff(in_entry.green, query.green);
        sq_b_reg      <= sq_diff(in_entry.blue,  query.blue);
        st1_entry_reg <= in_entry;
        st1_slot_reg  <= in_slot;
        // stage 2: sum
        st2_dist_reg  <= DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
        st2_entry_reg <= st1_entry_reg;
        st2_slot_reg  <= st1_slot_reg;
    end

    assign cand.valid = st2_valid_reg;
    assign cand.score = st2_dist_reg;
    assign cand.entry = st2_entry_reg;
    assign cand_slot  = st2_slot_reg;
    assign busy       = st1_valid_reg | st2_valid_reg;

endmodule

`default_nettype wire

### rtl/nearest_palette_color.sv
// Top level: palette store and nearest color search sequencer.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------------
//  s_      | in        | s_valid / s_ready  | action, slot, red, green, blue, tag
//  m_      | out       | m_valid / m_ready  | match color, tag, slot, no_match
//  cfg_    | in        | cfg_valid/cfg_ready| entries_in_use (always ready)
//
// A write word is taken while idle. A query with N slots in use (clipped to
// PALETTE_DEPTH) spends one scan step per slot (one RAM read per slot), then
// drains (RAM data into the unit and its two stages, until all are empty) and
// ends in the finish state, which loads the result; s_ready returns once the
// sequencer is back in idle. With N = 0 the query goes straight to the finish
// state.
// Reset (aresetn low, synchronous) clears the sequencer, the register and
// the output valid; the palette RAM holds no reset value.
// A waiting result does not block new input words; only the next query
// stalls in its finish state, with s_ready low, until that result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_palette_color_assert.svh"

module nearest_palette_color #(
    parameter int PALETTE_DEPTH = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] cfg_entries_in_use,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_action,
    input  wire logic [3:0] s_slot,
    input  wire logic [7:0] s_red,
    input  wire logic [7:0] s_green,
    input  wire logic [7:0] s_blue,
    input  wire logic [7:0] s_tag,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_match_red,
    output logic      [7:0] m_match_green,
    output logic      [7:0] m_match_blue,
    output logic      [7:0] m_match_tag,
    output logic      [3:0] m_match_slot,
    output logic            m_no_match
);

    import npc_pkg::*;

    localparam int AW  = $clog2(PALETTE_DEPTH > 1 ? PALETTE_DEPTH : 2);
    // largest slot count the 5-bit register can ask for on this palette
    localparam int SAT = (PALETTE_DEPTH < 31) ? PALETTE_DEPTH : 31;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] cfg_reg;
    logic [CFG_W-1:0] count_reg;
    logic [CFG_W-1:0] idx_reg;
    logic [CFG_W-1:0] count_sat;
    npc_color_t       query_reg;

    logic             in_acc, is_query, is_write;
    logic             rd_valid_reg;
    logic [AW-1:0]    rd_slot_reg;
    npc_entry_t       wr_entry, rd_entry;

    npc_cand_t        cand;
    logic [AW-1:0]    cand_slot;
    logic             dist_busy;

    logic             found_reg;
    logic [DIST_W-1:0] best_dist_reg;
    npc_entry_t       best_entry_reg;
    logic [AW-1:0]    best_slot_reg;

    logic             out_load;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign is_query  = in_acc && (s_action == ACT_QUERY);
    assign is_write  = in_acc && (s_action == ACT_WRITE) && (int'(s_slot) < PALETTE_DEPTH);
    assign count_sat = (cfg_reg > CFG_W'(SAT)) ? CFG_W'(SAT) : cfg_reg;
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid || m_ready);

    assign wr_entry.red   = s_red;
    assign wr_entry.green = s_green;
    assign wr_entry.blue  = s_blue;
    assign wr_entry.tag   = s_tag;

    npc_ram #(
        .WIDTH ($bits(npc_entry_t)),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (is_write),
        .waddr (AW'(s_slot)),
        .wdata (wr_entry),
        .raddr (AW'(idx_reg)),
        .rdata (rd_entry)
    );

    npc_dist #(
        .SLOT_W (AW)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .in_entry  (rd_entry),
        .in_slot   (rd_slot_reg),
        .query     (query_reg),
        .cand      (cand),
        .cand_slot (cand_slot),
        .busy      (dist_busy)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (is_query) begin
                    state_next = (count_sat == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (idx_reg == count_reg - 1'b1) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last candidate has been compared once all stages are empty
                if (!rd_valid_reg && !dist_busy && !cand.valid) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_SCAN);
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_entries_in_use;
            end
            // strict less-than keeps the lowest slot on a tie
            if (is_query) begin
                found_reg <= 1'b0;
            end else if (cand.valid && (!found_reg || cand.score < best_dist_reg)) begin
                found_reg <= 1'b1;
            end
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge aclk) begin
        if (is_query) begin
            count_reg       <= count_sat;
            idx_reg         <= '0;
            query_reg.red   <= s_red;
            query_reg.green <= s_green;
            query_reg.blue  <= s_blue;
        end else if (state_reg == ST_SCAN) begin
            idx_reg <= idx_reg + 1'b1;
        end
        rd_slot_reg <= AW'(idx_reg);
        if (cand.valid && (!found_reg || cand.score < best_dist_reg)) begin
            best_dist_reg  <= cand.score;
            best_entry_reg <= cand.entry;
            best_slot_reg  <= cand_slot;
        end
        if (out_load) begin
            if (found_reg) begin
                m_match_red   <= best_entry_reg.red;
                m_match_green <= best_entry_reg.green;
                m_match_blue  <= best_entry_reg.blue;
                m_match_tag   <= best_entry_reg.tag;
                m_match_slot  <= 4'(best_slot_reg);
                m_no_match    <= 1'b0;
            end else begin
                m_match_red   <= '0;
                m_match_green <= '0;
                m_match_blue  <= '0;
                m_match_tag   <= '0;
                m_match_slot  <= '0;
                m_no_match    <= 1'b1;
            end
        end
    end

    `NPC_ASSERT(a_idle_empty, aclk, aresetn, s_ready |-> (!rd_valid_reg && !dist_busy && !cand.valid), "pipeline busy while idle")
    `NPC_ASSERT(a_scan_bound, aclk, aresetn, (state_reg == ST_SCAN) |-> (idx_reg < count_reg), "scan index beyond slot count")
    `NPC_ASSERT(a_rose_finish, aclk, aresetn, $rose(m_valid) |-> $past(state_reg == ST_FINISH), "result raised outside finish")
    `NPC_ASSERT(a_nomatch_zero, aclk, aresetn, (m_valid && m_no_match) |-> (m_match_slot == 4'd0 && m_match_tag == 8'd0), "no_match result with nonzero fields")
    `NPC_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> (!m_valid && state_reg == ST_IDLE), "reset did not clear control")

endmodule

`default_nettype wire
